[hw/rtl/gqf_pkg.sv]
// Shared constants, types and a GF(2) helper function for the quadratic filter keystream block.
package gqf_pkg;

    // State vector length and derived sizes
    localparam int unsigned N          = 8;
    localparam int unsigned STATE_W    = 8;
    localparam int unsigned MAT_W      = 64;
    localparam int unsigned MASK_W     = 8;
    localparam int unsigned RUN_LEN    = N * N;
    localparam int unsigned CNT_W      = $clog2(RUN_LEN + 1);
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CNT_W-1:0] RUN_LEN_C = CNT_W'(RUN_LEN);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRANSITION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUADRATIC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CONST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_KEY   = 3'd4;

    typedef struct packed {
        logic [MAT_W-1:0]   transition_matrix;
        logic [MAT_W-1:0]   quadratic_matrix;
        logic [MASK_W-1:0]  linear_mask;
        logic               output_constant;
        logic [STATE_W-1:0] initial_key;
    } t_cfg;

    typedef struct packed {
        logic               keystream_bit;
        logic [STATE_W-1:0] state_now;
        logic               last_of_run;
    } t_result;

    // Row vector times matrix over GF(2); bit r*N+c is element (r, c)
    function automatic logic [STATE_W-1:0] vec_mat(input logic [STATE_W-1:0] v,
                                                   input logic [MAT_W-1:0]   m);
        logic [STATE_W-1:0] res;
        res = '0;
        for (int c = 0; c < N; c++) begin
            for (int r = 0; r < N; r++) begin
                res[c] = res[c] ^ (v[r] & m[r*N + c]);
            end
        end
        return res;
    endfunction

endpackage

[hw/rtl/gqf_if.sv]
// Stream and configuration channel interfaces for the keystream block.
interface gqf_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface gqf_out_if;
    import gqf_pkg::*;
    logic               valid;
    logic               ready;
    logic               keystream_bit;
    logic [STATE_W-1:0] state_now;
    logic               last_of_run;

    modport source (output valid, output keystream_bit, output state_now,
                    output last_of_run, input ready);
    modport sink   (input valid, input keystream_bit, input state_now,
                    input last_of_run, output ready);
endinterface

interface gqf_cfg_if;
    import gqf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/gf2_quadratic_filter_keystream.sv]
// Top level of the GF(2) quadratic filter keystream generator.
//
// Channels: i_in carries one item per transfer (restart bit); o_out returns
// one result per item (keystream_bit, state_now, last_of_run); i_cfg writes
// the five configuration registers by index and is always ready. Indexes
// past the last register are dropped. Write configuration only while idle.
//
// Each input transfer runs the whole step (reload on restart, linear update
// through the transition matrix, quadratic and linear filter terms, run
// counter) in combinational logic ahead of the output register, which holds
// the result, or the skid stage while the receiver stalls. Throughput is one
// item per cycle while i_in.ready is high, set by the single state register loop.
//
// Reset clears the configuration, the state vector and the run counter, so
// without a restart the generator steps from the all-zero state. When the
// receiver stalls, one more result parks in a skid stage and i_in.ready
// drops until the receiver takes data again; nothing is lost or repeated.
module gf2_quadratic_filter_keystream (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gqf_in_if.sink    i_in,
    gqf_out_if.source o_out,
    gqf_cfg_if.sink   i_cfg
);
    import gqf_pkg::*;

    t_cfg    cfg;
    t_result result;
    logic    buf_ready;
    logic    step;

    assign i_in.ready = buf_ready;
    assign step       = i_in.valid && buf_ready;

    gqf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    gqf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_step    (step),
        .i_restart (i_in.restart),
        .o_result  (result)
    );

    gqf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_out   (o_out)
    );

endmodule

[hw/rtl/gqf_cfg_regs.sv]
// Configuration register file for the keystream block.
module gqf_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gqf_cfg_if.sink       i_cfg,
    output gqf_pkg::t_cfg o_cfg
);
    import gqf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Always take a write
    assign i_cfg.ready = 1'b1;

    // Decode the write; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TRANSITION: n_cfg.transition_matrix = i_cfg.data;
                REG_QUADRATIC:  n_cfg.quadratic_matrix  = i_cfg.data;
                REG_LIN_MASK:   n_cfg.linear_mask       = i_cfg.data[MASK_W-1:0];
                REG_OUT_CONST:  n_cfg.output_constant   = i_cfg.data[0];
                REG_INIT_KEY:   n_cfg.initial_key       = i_cfg.data[STATE_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/gqf_core.sv]
// State register, run counter and filter logic: one step per accepted transfer.
module gqf_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gqf_pkg::t_cfg    i_cfg,
    input  logic             i_step,
    input  logic             i_restart,
    output gqf_pkg::t_result o_result
);
    import gqf_pkg::*;

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;
    logic [CNT_W-1:0]   r_run_cnt;
    logic [CNT_W-1:0]   n_run_cnt;
    logic [STATE_W-1:0] base_state;
    logic [CNT_W-1:0]   base_cnt;
    logic [STATE_W-1:0] sq;
    logic               quad_bit;
    logic               lin_bit;

    // Restart reloads the key and clears the count before the step
    assign base_state = i_restart ? i_cfg.initial_key : r_state;
    assign base_cnt   = i_restart ? '0 : r_run_cnt;

    // Linear update, then quadratic and linear filter terms
    assign n_state  = vec_mat(base_state, i_cfg.transition_matrix);
    assign sq       = vec_mat(n_state, i_cfg.quadratic_matrix);
    assign quad_bit = ^(sq & n_state);
    assign lin_bit  = ^(i_cfg.linear_mask & n_state);

    // Count up to the run length and hold there
    assign n_run_cnt = (base_cnt < RUN_LEN_C) ? base_cnt + 1'b1 : base_cnt;

    assign o_result.keystream_bit = quad_bit ^ lin_bit ^ i_cfg.output_constant;
    assign o_result.state_now     = n_state;
    assign o_result.last_of_run   = (base_cnt < RUN_LEN_C) && (n_run_cnt == RUN_LEN_C);

    // Advance state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_run_cnt <= '0;
        end else if (i_step) begin
            r_state   <= n_state;
            r_run_cnt <= n_run_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_cnt <= RUN_LEN_C)
        else $error("run count beyond run length");

    a_restart_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_restart |=> r_run_cnt == CNT_W'(1))
        else $error("run count not one after restart");

    a_last_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.last_of_run |=> r_run_cnt == RUN_LEN_C)
        else $error("last of run without full count");

endmodule

[hw/rtl/gqf_out_buf.sv]
// Output register with a skid stage so a stalled receiver never drops a result.
module gqf_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gqf_pkg::t_result i_data,
    output logic             o_ready,
    gqf_out_if.source        o_out
);
    import gqf_pkg::*;

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out_data;
    t_result n_out_data;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid_data;
    t_result n_skid_data;
    logic    take;

    assign take    = r_out_valid && o_out.ready;
    assign o_ready = !r_skid_valid;

    // Refill the output stage from skid first, else from the new transfer; while it is held, park the transfer in skid
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_push;
                n_out_data  = i_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid_data  = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.keystream_bit = r_out_data.keystream_bit;
    assign o_out.state_now     = r_out_data.state_now;
    assign o_out.last_of_run   = r_out_data.last_of_run;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds data ahead of output stage");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !o_out.ready |=> r_skid_valid)
        else $error("skid entry lost while stalled");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("transfer taken with both stages full");

endmodule
